// ----- hdl/bsm_pkg.sv -----
`default_nettype none

package bsm_pkg;

  // fixed widths of the channel fields and the size register
  localparam int PIX_W            = 16;
  localparam int FS_W             = 11;
  localparam int FRAME_SIZE_RESET = 32;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // per-request classification made by the front
  typedef struct packed {
    logic emit;       // request produces a result
    logic rlo;        // window row above the center lies in the image
    logic rhi;        // window row below the center lies in the image
    logic clo;        // window column left of the center lies in the image
    logic chi;        // window column right of the center lies in the image
    logic frame_end;  // last result of the frame
  } ctl_t;

endpackage

`default_nettype wire

// ----- hdl/bsm_ifs.sv -----
`default_nettype none

interface bsm_in_if;
  import bsm_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;
  logic             is_pad;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output is_pad, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  input is_pad, output ready);
endinterface

interface bsm_out_if;
  import bsm_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input frame_end, output ready);
endinterface

`default_nettype wire

// ----- hdl/bsm_ram.sv -----
`default_nettype none

module bsm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // read-first: a read at the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/bsm_front.sv -----
`default_nettype none

module bsm_front #(
  parameter int MAX_SIZE   = 1024,
  parameter int COLOR_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bsm_in_if.sink                             in_px,
  input  wire logic                          cfg_we,
  input  wire logic [bsm_pkg::FS_W-1:0]      cfg_wdata,
  input  wire logic [bsm_pkg::Q_CNT_W-1:0]   q_count,
  output logic                               push_v,
  output bsm_pkg::ctl_t                      push_ctl,
  output logic      [3*COLOR_BITS-1:0]       push_upper,
  output logic      [3*COLOR_BITS-1:0]       push_middle,
  output logic      [3*COLOR_BITS-1:0]       push_lower
);
  import bsm_pkg::*;

  localparam int PXW       = 3*COLOR_BITS;
  localparam int AW        = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int ROW_W     = $clog2(MAX_SIZE + 2);
  localparam int NM1_RESET = ((FRAME_SIZE_RESET > MAX_SIZE) ? MAX_SIZE : FRAME_SIZE_RESET) - 1;

  logic [AW-1:0]    nm1_r, nm1_nxt;
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [AW-1:0]    rrow_r, rrow_nxt;
  logic [AW-1:0]    rcol_r, rcol_nxt;

  logic             acc;
  logic [PXW-1:0]   px;
  ctl_t             ctl;

  logic             f1_v_r;
  ctl_t             f1_ctl_r;
  logic [PXW-1:0]   f1_px_r;
  logic             f1_par_r;
  logic [PXW-1:0]   even_q;
  logic [PXW-1:0]   odd_q;

  // one request in flight between accept and the queue, so keep a slot for it
  assign in_px.ready = (int'(q_count) + int'(f1_v_r)) < Q_DEPTH;
  assign acc         = in_px.valid && in_px.ready;

  // a pad inside the frame counts as a black pixel
  assign px = in_px.is_pad ? '0 : {in_px.in_blue[COLOR_BITS-1:0],
                                   in_px.in_green[COLOR_BITS-1:0],
                                   in_px.in_red[COLOR_BITS-1:0]};

  always_comb begin
    ctl.emit      = (row_r > ROW_W'(1)) || ((row_r == ROW_W'(1)) && (col_r != '0));
    ctl.rlo       = (rrow_r != '0);
    ctl.rhi       = (rrow_r != nm1_r);
    ctl.clo       = (rcol_r != '0);
    ctl.chi       = (rcol_r != nm1_r);
    ctl.frame_end = !ctl.rhi && !ctl.chi;
  end

  always_comb begin
    nm1_nxt  = nm1_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    rrow_nxt = rrow_r;
    rcol_nxt = rcol_r;
    if (cfg_we) begin
      if (int'(cfg_wdata) > MAX_SIZE) begin
        nm1_nxt = AW'(MAX_SIZE - 1);
      end else if (cfg_wdata == '0) begin
        nm1_nxt = '0;
      end else begin
        nm1_nxt = AW'(cfg_wdata - FS_W'(1));
      end
      col_nxt  = '0;
      row_nxt  = '0;
      rrow_nxt = '0;
      rcol_nxt = '0;
    end else if (acc) begin
      if (col_r == nm1_r) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
      if (ctl.emit) begin
        if (ctl.frame_end) begin
          col_nxt  = '0;
          row_nxt  = '0;
          rrow_nxt = '0;
          rcol_nxt = '0;
        end else if (rcol_r == nm1_r) begin
          rcol_nxt = '0;
          rrow_nxt = rrow_r + AW'(1);
        end else begin
          rcol_nxt = rcol_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm1_r  <= AW'(NM1_RESET);
      col_r  <= '0;
      row_r  <= '0;
      rrow_r <= '0;
      rcol_r <= '0;
      f1_v_r <= 1'b0;
    end else begin
      nm1_r  <= nm1_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      rrow_r <= rrow_nxt;
      rcol_r <= rcol_nxt;
      f1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1_ctl_r <= ctl;
      f1_px_r  <= px;
      f1_par_r <= row_r[0];
    end
  end

  // line stores split by row parity: the store of this row's parity holds two rows up,
  // the other one the row just above; the new pixel replaces the two-rows-up entry
  bsm_ram #(.WIDTH(PXW), .DEPTH(MAX_SIZE)) u_even (
    .clk   (clk),
    .we    (acc && !row_r[0]),
    .waddr (col_r),
    .wdata (px),
    .raddr (col_r),
    .rdata (even_q)
  );

  bsm_ram #(.WIDTH(PXW), .DEPTH(MAX_SIZE)) u_odd (
    .clk   (clk),
    .we    (acc && row_r[0]),
    .waddr (col_r),
    .wdata (px),
    .raddr (col_r),
    .rdata (odd_q)
  );

  assign push_v      = f1_v_r;
  assign push_ctl    = f1_ctl_r;
  assign push_upper  = f1_par_r ? odd_q : even_q;
  assign push_middle = f1_par_r ? even_q : odd_q;
  assign push_lower  = f1_px_r;

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= nm1_r))
    else $error("input column beyond frame width");

  a_res_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (rrow_r <= nm1_r) && (rcol_r <= nm1_r))
    else $error("result position beyond frame");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(row_r) <= int'(nm1_r) + 2))
    else $error("input row ran past the drain");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    f1_v_r |-> (int'(q_count) < Q_DEPTH))
    else $error("request in flight with no queue slot");

endmodule

`default_nettype wire

// ----- hdl/bsm_queue.sv -----
`default_nettype none

module bsm_queue #(
  parameter int WIDTH = 150
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [WIDTH-1:0]            push_data,
  input  wire logic                        pop,
  output logic      [WIDTH-1:0]            head_data,
  output logic                             nonempty,
  output logic      [bsm_pkg::Q_CNT_W-1:0] count
);
  import bsm_pkg::*;

  logic [WIDTH-1:0]   slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data = slot_r[rd_ptr_r];
  assign nonempty  = (count_r != '0);
  assign count     = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (int'(count_r) < Q_DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue underflow");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && pop) |=> $stable(count_r))
    else $error("queue count moved on push with pop");

endmodule

`default_nettype wire

// ----- hdl/bsm_back.sv -----
`default_nettype none

module bsm_back #(
  parameter int COLOR_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire bsm_pkg::ctl_t           head_ctl,
  input  wire logic [3*COLOR_BITS-1:0] head_upper,
  input  wire logic [3*COLOR_BITS-1:0] head_middle,
  input  wire logic [3*COLOR_BITS-1:0] head_lower,
  input  wire logic                    q_nonempty,
  output logic                         pop,
  bsm_out_if.source                    out_px
);
  import bsm_pkg::*;

  localparam int PXW         = 3*COLOR_BITS;
  localparam int CSW         = COLOR_BITS + 2;   // sum of three colors
  localparam int TW          = COLOR_BITS + 4;   // sum of nine colors
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;
  localparam int PW          = TW + RECIP_W;
  localparam int TOT_MAX     = 9 * ((1 << COLOR_BITS) - 1);

  // ceil(2^24 / d): exact truncated quotient for any nine-color sum
  localparam logic [RECIP_W-1:0] RECIP_DIV1 = 25'd16777216;
  localparam logic [RECIP_W-1:0] RECIP_DIV2 = 25'd8388608;
  localparam logic [RECIP_W-1:0] RECIP_DIV3 = 25'd5592406;
  localparam logic [RECIP_W-1:0] RECIP_DIV4 = 25'd4194304;
  localparam logic [RECIP_W-1:0] RECIP_DIV6 = 25'd2796203;
  localparam logic [RECIP_W-1:0] RECIP_DIV9 = 25'd1864136;

  logic               adv;

  logic [PXW-1:0]     win_r [3][3];   // [row: upper, middle, lower][column: old..new]
  logic               s0_v_r;
  ctl_t               s0_ctl_r;

  logic [CSW-1:0]     cs_nxt [3][3];  // [color][column]
  logic [CSW-1:0]     cs_r   [3][3];
  logic [RECIP_W-1:0] recip_nxt;
  logic [RECIP_W-1:0] recip_r;
  logic [1:0]         nrows;
  logic [1:0]         ncols;
  logic               s1_v_r;
  ctl_t               s1_ctl_r;

  logic [TW-1:0]      tot_nxt [3];
  logic [TW-1:0]      tot_r   [3];
  logic [RECIP_W-1:0] recip2_r;
  logic               s2_v_r;
  logic               s2_fend_r;

  logic [PW-1:0]      prod_r [3];
  logic               s3_v_r;
  logic               s3_fend_r;

  assign adv = !out_px.valid || out_px.ready;
  assign pop = adv && q_nonempty;

  // every request shifts the window, emitting or not
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= head_upper;
      win_r[1][2] <= head_middle;
      win_r[2][2] <= head_lower;
    end
  end

  // column sums with rows outside the image dropped
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        cs_nxt[k][j] =
            (s0_ctl_r.rlo ? CSW'(win_r[0][j][k*COLOR_BITS +: COLOR_BITS]) : '0)
          + CSW'(win_r[1][j][k*COLOR_BITS +: COLOR_BITS])
          + (s0_ctl_r.rhi ? CSW'(win_r[2][j][k*COLOR_BITS +: COLOR_BITS]) : '0);
      end
    end
  end

  always_comb begin
    nrows = 2'd1 + {1'b0, s0_ctl_r.rlo} + {1'b0, s0_ctl_r.rhi};
    ncols = 2'd1 + {1'b0, s0_ctl_r.clo} + {1'b0, s0_ctl_r.chi};
    case ({nrows, ncols})
      {2'd1, 2'd1}: recip_nxt = RECIP_DIV1;
      {2'd1, 2'd2}: recip_nxt = RECIP_DIV2;
      {2'd2, 2'd1}: recip_nxt = RECIP_DIV2;
      {2'd1, 2'd3}: recip_nxt = RECIP_DIV3;
      {2'd3, 2'd1}: recip_nxt = RECIP_DIV3;
      {2'd2, 2'd2}: recip_nxt = RECIP_DIV4;
      {2'd2, 2'd3}: recip_nxt = RECIP_DIV6;
      {2'd3, 2'd2}: recip_nxt = RECIP_DIV6;
      {2'd3, 2'd3}: recip_nxt = RECIP_DIV9;
      default:      recip_nxt = RECIP_DIV1;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tot_nxt[k] = (s1_ctl_r.clo ? TW'(cs_r[k][0]) : '0)
                 + TW'(cs_r[k][1])
                 + (s1_ctl_r.chi ? TW'(cs_r[k][2]) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r       <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      out_px.valid <= 1'b0;
    end else if (adv) begin
      s0_v_r       <= pop && head_ctl.emit;
      s1_v_r       <= s0_v_r;
      s2_v_r       <= s1_v_r;
      s3_v_r       <= s2_v_r;
      out_px.valid <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ctl_r  <= head_ctl;
      cs_r      <= cs_nxt;
      recip_r   <= recip_nxt;
      s1_ctl_r  <= s0_ctl_r;
      tot_r     <= tot_nxt;
      recip2_r  <= recip_r;
      s2_fend_r <= s1_ctl_r.frame_end;
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PW'(tot_r[k]) * PW'(recip2_r);
      end
      s3_fend_r        <= s2_fend_r;
      out_px.out_red   <= PIX_W'(prod_r[0][RECIP_SHIFT +: COLOR_BITS]);
      out_px.out_green <= PIX_W'(prod_r[1][RECIP_SHIFT +: COLOR_BITS]);
      out_px.out_blue  <= PIX_W'(prod_r[2][RECIP_SHIFT +: COLOR_BITS]);
      out_px.frame_end <= s3_fend_r;
    end
  end

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (int'(tot_r[0]) <= TOT_MAX) && (int'(tot_r[1]) <= TOT_MAX)
               && (int'(tot_r[2]) <= TOT_MAX))
    else $error("window sum out of range");

  a_window_shift: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (win_r[1][1] === $past(win_r[1][2])) && (win_r[1][2] === $past(head_middle)))
    else $error("window did not shift on pop");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && adv) |=> out_px.valid)
    else $error("finished result lost before the output register");

endmodule

`default_nettype wire

// ----- hdl/box_smooth_3x3.sv -----
`default_nettype none

// 3x3 box smoothing of a square RGB image streamed in raster order, one pixel per
// request. Each result is the per-color truncated mean of a pixel and its in-image
// neighbors (divide by 9 inside, 6 on an edge, 4 in a corner). Results trail their
// input by one row plus one pixel, so after the frame send frame_size+1 pad requests
// to drain it; frame_end marks the last result, after which a new frame starts.
// Writing cfg_wdata (size, 0 acts as 1, clamped to MAX_SIZE) restarts the frame and
// must only happen while the block is empty. Sustained rate is one pixel per clock
// while the output accepts results: the two line stores are split by row parity, so
// each request needs one read of each store and one write to one of them in its accept
// cycle. A result passes the front register, the queue and back stages s0 to s3 on its
// way to the output register; the front keeps accepting while the output is stalled
// until its four-entry queue fills. The line stores are not cleared after reset:
// entries from earlier frames only ever fall in clipped parts of a window.
module box_smooth_3x3 #(
  parameter int MAX_SIZE   = 1024,
  parameter int COLOR_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  bsm_in_if.sink                        in_px,
  bsm_out_if.source                     out_px,
  input  wire logic                     cfg_we,
  input  wire logic [bsm_pkg::FS_W-1:0] cfg_wdata
);
  import bsm_pkg::*;

  localparam int PXW = 3*COLOR_BITS;
  localparam int QW  = $bits(ctl_t) + 3*PXW;

  logic               push_v;
  ctl_t               push_ctl;
  logic [PXW-1:0]     push_upper;
  logic [PXW-1:0]     push_middle;
  logic [PXW-1:0]     push_lower;
  logic [QW-1:0]      head_data;
  ctl_t               head_ctl;
  logic [PXW-1:0]     head_upper;
  logic [PXW-1:0]     head_middle;
  logic [PXW-1:0]     head_lower;
  logic               q_nonempty;
  logic [Q_CNT_W-1:0] q_count;
  logic               pop;

  bsm_front #(.MAX_SIZE(MAX_SIZE), .COLOR_BITS(COLOR_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_px       (in_px),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_count     (q_count),
    .push_v      (push_v),
    .push_ctl    (push_ctl),
    .push_upper  (push_upper),
    .push_middle (push_middle),
    .push_lower  (push_lower)
  );

  bsm_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_v),
    .push_data ({push_ctl, push_upper, push_middle, push_lower}),
    .pop       (pop),
    .head_data (head_data),
    .nonempty  (q_nonempty),
    .count     (q_count)
  );

  assign {head_ctl, head_upper, head_middle, head_lower} = head_data;

  bsm_back #(.COLOR_BITS(COLOR_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_ctl    (head_ctl),
    .head_upper  (head_upper),
    .head_middle (head_middle),
    .head_lower  (head_lower),
    .q_nonempty  (q_nonempty),
    .pop         (pop),
    .out_px      (out_px)
  );

endmodule

`default_nettype wire
